// File: hw/rtl/cpap_pkg.sv
// Shared types and constants for the polygon plane clipper.
package cpap_pkg;

   localparam int CoordWidth = 32;
   localparam int ColorWidth = 16;
   localparam int PlaneWidth = 64;
   localparam int CountWidth = 7;
   localparam int CountLimit = 127;

   // Configuration register indexes.
   localparam logic [1:0] CSR_PLANE_A = 2'd0;
   localparam logic [1:0] CSR_PLANE_B = 2'd1;
   localparam logic [1:0] CSR_PLANE_C = 2'd2;
   localparam logic [1:0] CSR_PLANE_D = 2'd3;

   // One classified vertex as it passes from the front part to the back part.
   typedef struct packed {
      logic signed [CoordWidth-1:0] x;
      logic signed [CoordWidth-1:0] y;
      logic signed [CoordWidth-1:0] z;
      logic [ColorWidth-1:0]        r;
      logic [ColorWidth-1:0]        g;
      logic [ColorWidth-1:0]        b;
      logic signed [PlaneWidth-1:0] f;
      logic                         last;
   } vtx_type;

   // Signed add that clamps to the 64-bit range.
   function automatic logic signed [PlaneWidth-1:0] sat_add(
      input logic signed [PlaneWidth-1:0] a,
      input logic signed [PlaneWidth-1:0] b
   );
      logic signed [PlaneWidth:0] s;
      logic signed [PlaneWidth-1:0] res;
      s = {a[PlaneWidth-1], a} + {b[PlaneWidth-1], b};
      if (s[PlaneWidth] != s[PlaneWidth-1]) begin
         res = s[PlaneWidth] ? {1'b1, {(PlaneWidth-1){1'b0}}} : {1'b0, {(PlaneWidth-1){1'b1}}};
      end else begin
         res = s[PlaneWidth-1:0];
      end
      return res;
   endfunction

endpackage

// File: hw/rtl/cpap_front.sv
// Front part: holds the plane registers, takes vertices and works out the plane value.
module cpap_front
   import cpap_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [143:0]          req_tdata,
   input  logic                  req_tlast,
   output logic                  push,
   output vtx_type               push_data,
   input  logic                  q_full
);

   typedef enum logic [1:0] {F_IDLE, F_CALC, F_PUSH} fstate_type;

   fstate_type                   state_ff;
   logic signed [31:0]           plane_a_ff, plane_b_ff, plane_c_ff, plane_d_ff;
   vtx_type                      rec_ff;
   logic [2:0]                   step_ff;
   logic signed [63:0]           prod_ff;
   logic signed [31:0]           coef;
   logic signed [31:0]           opnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_a_ff <= '0;
         plane_b_ff <= '0;
         plane_c_ff <= '0;
         plane_d_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PLANE_A: plane_a_ff <= csr_wdata;
            CSR_PLANE_B: plane_b_ff <= csr_wdata;
            CSR_PLANE_C: plane_c_ff <= csr_wdata;
            CSR_PLANE_D: plane_d_ff <= csr_wdata;
            default:     plane_a_ff <= plane_a_ff;
         endcase
      end
   end

   // The constant term enters as d times 2^16 through the same multiplier.
   always_comb begin
      case (step_ff[1:0])
         2'd0: begin coef = plane_a_ff; opnd = rec_ff.x; end
         2'd1: begin coef = plane_b_ff; opnd = rec_ff.y; end
         2'd2: begin coef = plane_c_ff; opnd = rec_ff.z; end
         default: begin coef = plane_d_ff; opnd = 32'sh0001_0000; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         step_ff  <= '0;
      end else begin
         case (state_ff)
            F_IDLE: begin
               if (req_tvalid) begin
                  rec_ff.x    <= req_tdata[31:0];
                  rec_ff.y    <= req_tdata[63:32];
                  rec_ff.z    <= req_tdata[95:64];
                  rec_ff.r    <= req_tdata[111:96];
                  rec_ff.g    <= req_tdata[127:112];
                  rec_ff.b    <= req_tdata[143:128];
                  rec_ff.last <= req_tlast;
                  rec_ff.f    <= '0;
                  step_ff     <= '0;
                  state_ff    <= F_CALC;
               end
            end
            F_CALC: begin
               if (step_ff != 3'd4) begin
                  prod_ff <= coef * opnd;
               end
               if (step_ff != 3'd0) begin
                  rec_ff.f <= sat_add(rec_ff.f, prod_ff);
               end
               step_ff <= step_ff + 3'd1;
               if (step_ff == 3'd4) begin
                  state_ff <= F_PUSH;
               end
            end
            F_PUSH: begin
               if (!q_full) begin
                  state_ff <= F_IDLE;
               end
            end
            default: state_ff <= F_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == F_IDLE);
   assign push       = (state_ff == F_PUSH) && !q_full;
   assign push_data  = rec_ff;

endmodule

// File: hw/rtl/cpap_queue.sv
// Two-entry queue of classified vertices between the front and back parts.
module cpap_queue
   import cpap_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  vtx_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    valid,
   output vtx_type head
);

   vtx_type    mem_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] fill_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         fill_ff <= fill_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   assign full  = (fill_ff == 2'd2);
   assign valid = (fill_ff != 2'd0);
   assign head  = mem_ff[rd_ptr_ff];

endmodule

// File: hw/rtl/cpap_back.sv
// Back part: walks the edges of each vertex, divides for t, interpolates and emits results.
module cpap_back
   import cpap_pkg::*;
#(
   parameter int MAX_POLY_VERTICES = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          q_valid,
   input  vtx_type       q_head,
   output logic          q_pop,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [151:0]  rsp_tdata,
   output logic          rsp_tuser,
   output logic          rsp_tlast
);

   localparam int CountCap = (MAX_POLY_VERTICES + 1 > CountLimit) ? CountLimit
                                                                 : MAX_POLY_VERTICES + 1;

   typedef enum logic [3:0] {
      S_IDLE, S_EDGE, S_DIV, S_LERP, S_EMIT_X, S_EMIT_V, S_EDGE_DONE, S_MARKER, S_FINISH
   } bstate_type;

   bstate_type                  state_ff;
   vtx_type                     cur_ff, e0_ff, e1_ff, first_ff, prev_ff;
   logic                        at_start_ff;
   logic [CountWidth-1:0]       count_ff;
   logic                        edge_sel_ff;
   logic                        close_emits_ff;
   logic                        emitted_ff;
   logic [63:0]                 r_ff, den_ff;
   logic [15:0]                 q_ff;
   logic [3:0]                  iter_ff;
   logic [16:0]                 t_ff;
   logic [2:0]                  k_ff;
   logic signed [50:0]          prod_ff;
   logic [31:0]                 res_ff [6];

   logic                        valid_ff;
   logic [31:0]                 ox_ff, oy_ff, oz_ff;
   logic [15:0]                 or_ff, og_ff, ob_ff;
   logic                        isv_ff, end_ff;
   logic [CountWidth-1:0]       ocnt_ff;

   logic                        out_free;
   logic                        out_load;
   logic                        in0, in1, edge_final;
   logic [CountWidth-1:0]       count_in;
   logic [63:0]                 mag0, mag1;
   logic [63:0]                 r_shift, r_in;
   logic                        take;
   logic signed [32:0]          lo_v0, lo_v1, wr_v0;
   logic signed [32:0]          diff;
   logic signed [50:0]          quot;

   function automatic logic signed [32:0] chan(input vtx_type v, input logic [2:0] k);
      logic signed [32:0] c;
      case (k)
         3'd0:    c = {v.x[31], v.x};
         3'd1:    c = {v.y[31], v.y};
         3'd2:    c = {v.z[31], v.z};
         3'd3:    c = {17'd0, v.r};
         3'd4:    c = {17'd0, v.g};
         default: c = {17'd0, v.b};
      endcase
      return c;
   endfunction

   assign out_free   = !valid_ff || rsp_tready;
   // A new beat enters the output register in this cycle.
   assign out_load   = out_free && (state_ff inside {S_EMIT_X, S_EMIT_V, S_MARKER});
   assign in0        = (e0_ff.f > 64'sd0);
   assign in1        = (e1_ff.f > 64'sd0);
   assign edge_final = edge_sel_ff || (cur_ff.last && !close_emits_ff);
   assign count_in   = (count_ff < CountWidth'(CountCap)) ? count_ff + 1'b1 : count_ff;

   assign mag0    = e0_ff.f[63] ? 64'd0 - e0_ff.f : e0_ff.f;
   assign mag1    = e1_ff.f[63] ? 64'd0 - e1_ff.f : e1_ff.f;
   // Restoring step; the bit shifted out at the top forces a subtract.
   assign r_shift = {r_ff[62:0], 1'b0};
   assign take    = r_ff[63] || (r_shift >= den_ff);
   assign r_in    = take ? r_shift - den_ff : r_shift;

   assign lo_v0 = chan(e0_ff, k_ff);
   assign lo_v1 = chan(e1_ff, k_ff);
   assign diff  = lo_v1 - lo_v0;
   assign wr_v0 = chan(e0_ff, k_ff - 3'd1);
   // Arithmetic shift after a bias gives the quotient rounded toward zero.
   assign quot  = (prod_ff + (prod_ff[50] ? 51'sd65535 : 51'sd0)) >>> 16;

   assign q_pop = (state_ff == S_IDLE) && q_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         at_start_ff <= 1'b1;
         count_ff    <= '0;
         edge_sel_ff <= 1'b0;
         emitted_ff  <= 1'b0;
         valid_ff    <= 1'b0;
      end else begin
         if (rsp_tready && !out_load) begin
            valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cur_ff     <= q_head;
                  emitted_ff <= 1'b0;
                  if (at_start_ff) begin
                     first_ff       <= q_head;
                     count_ff       <= '0;
                     close_emits_ff <= (q_head.f > 64'sd0);
                     e0_ff          <= q_head;
                     e1_ff          <= q_head;
                     edge_sel_ff    <= 1'b1;
                     state_ff       <= q_head.last ? S_EDGE : S_FINISH;
                  end else begin
                     close_emits_ff <= (q_head.f > 64'sd0) || (first_ff.f > 64'sd0);
                     e0_ff          <= prev_ff;
                     e1_ff          <= q_head;
                     edge_sel_ff    <= 1'b0;
                     state_ff       <= S_EDGE;
                  end
               end
            end
            S_EDGE: begin
               k_ff <= '0;
               if (in0 != in1) begin
                  r_ff    <= mag0;
                  den_ff  <= mag0 + mag1;
                  q_ff    <= '0;
                  iter_ff <= '0;
                  if (mag1 == 64'd0) begin
                     t_ff     <= 17'h1_0000;
                     state_ff <= S_LERP;
                  end else begin
                     state_ff <= S_DIV;
                  end
               end else if (in1) begin
                  state_ff <= S_EMIT_V;
               end else begin
                  state_ff <= S_EDGE_DONE;
               end
            end
            S_DIV: begin
               r_ff    <= r_in;
               q_ff    <= {q_ff[14:0], take};
               iter_ff <= iter_ff + 4'd1;
               if (iter_ff == 4'd15) begin
                  t_ff     <= {1'b0, q_ff[14:0], take};
                  state_ff <= S_LERP;
               end
            end
            S_LERP: begin
               // One channel enters the multiplier while the previous one is summed.
               if (k_ff != 3'd6) begin
                  prod_ff <= diff * $signed({1'b0, t_ff});
               end
               if (k_ff != 3'd0) begin
                  res_ff[k_ff - 3'd1] <= 32'(wr_v0 + 33'(quot));
               end
               k_ff <= k_ff + 3'd1;
               if (k_ff == 3'd6) begin
                  state_ff <= S_EMIT_X;
               end
            end
            S_EMIT_X: begin
               if (out_free) begin
                  valid_ff   <= 1'b1;
                  ox_ff      <= res_ff[0];
                  oy_ff      <= res_ff[1];
                  oz_ff      <= res_ff[2];
                  or_ff      <= res_ff[3][15:0];
                  og_ff      <= res_ff[4][15:0];
                  ob_ff      <= res_ff[5][15:0];
                  isv_ff     <= 1'b1;
                  end_ff     <= edge_final && !in1;
                  ocnt_ff    <= count_in;
                  count_ff   <= count_in;
                  emitted_ff <= 1'b1;
                  state_ff   <= in1 ? S_EMIT_V : S_EDGE_DONE;
               end
            end
            S_EMIT_V: begin
               if (out_free) begin
                  valid_ff   <= 1'b1;
                  ox_ff      <= e1_ff.x;
                  oy_ff      <= e1_ff.y;
                  oz_ff      <= e1_ff.z;
                  or_ff      <= e1_ff.r;
                  og_ff      <= e1_ff.g;
                  ob_ff      <= e1_ff.b;
                  isv_ff     <= 1'b1;
                  end_ff     <= edge_final;
                  ocnt_ff    <= count_in;
                  count_ff   <= count_in;
                  emitted_ff <= 1'b1;
                  state_ff   <= S_EDGE_DONE;
               end
            end
            S_EDGE_DONE: begin
               if (!edge_sel_ff && cur_ff.last) begin
                  e0_ff       <= cur_ff;
                  e1_ff       <= first_ff;
                  edge_sel_ff <= 1'b1;
                  state_ff    <= S_EDGE;
               end else if (cur_ff.last && !emitted_ff) begin
                  state_ff <= S_MARKER;
               end else begin
                  state_ff <= S_FINISH;
               end
            end
            S_MARKER: begin
               if (out_free) begin
                  valid_ff <= 1'b1;
                  ox_ff    <= '0;
                  oy_ff    <= '0;
                  oz_ff    <= '0;
                  or_ff    <= '0;
                  og_ff    <= '0;
                  ob_ff    <= '0;
                  isv_ff   <= 1'b0;
                  end_ff   <= 1'b1;
                  ocnt_ff  <= count_ff;
                  state_ff <= S_FINISH;
               end
            end
            S_FINISH: begin
               if (cur_ff.last) begin
                  at_start_ff <= 1'b1;
                  count_ff    <= '0;
               end else begin
                  prev_ff     <= cur_ff;
                  at_start_ff <= 1'b0;
               end
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {1'b0, ocnt_ff, ob_ff, og_ff, or_ff, oz_ff, oy_ff, ox_ff};
   assign rsp_tuser  = isv_ff;
   assign rsp_tlast  = end_ff;

endmodule

// File: hw/rtl/clip_polygon_against_plane_unit.sv
// The front part classifies each vertex against the plane; the back part then walks its edges.
// A crossing edge takes a restoring divide, skipped when the far vertex lies on the plane,
// and an interpolation of all six channels. The front part takes a vertex only once the last is
// pushed; the divider and single interpolation multiplier set the rate for crossing edges.
// Reset is synchronous and active high; it clears the plane registers to zero,
// returns to polygon start and empties the queue and output register.
module clip_polygon_against_plane_unit
   import cpap_pkg::*;
#(
   parameter int MAX_POLY_VERTICES = 64
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_wdata,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [143:0]  req_tdata,   // pos_x, pos_y, pos_z, col_r, col_g, col_b
   input  logic          req_tlast,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [151:0]  rsp_tdata,   // out_x, out_y, out_z, out_r, out_g, out_b, vertex_count
   output logic          rsp_tuser,   // is_vertex
   output logic          rsp_tlast
);

   logic    push, q_full, q_pop, q_valid;
   vtx_type push_data, q_head;

   cpap_front u_front (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .push, .push_data, .q_full
   );

   cpap_queue u_queue (
      .clock, .reset, .push, .push_data, .full(q_full),
      .pop(q_pop), .valid(q_valid), .head(q_head)
   );

   cpap_back #(.MAX_POLY_VERTICES(MAX_POLY_VERTICES)) u_back (
      .clock, .reset, .q_valid, .q_head, .q_pop,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast
   );

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the single-plane polygon clipper.
`timescale 1ns / 100ps

module tb;
   import cpap_pkg::*;

   localparam int VertexCap = 64;
   localparam int CountSat = (VertexCap + 1 > CountLimit) ? CountLimit : VertexCap + 1;
   localparam int SettleCycles = 120;
   localparam int StallLimit = 20000;

   typedef struct {
      longint      p[3];
      int unsigned c[3];
      longint      f;
   } corner_type;

   typedef struct packed {
      logic [31:0] x, y, z;
      logic [15:0] r, g, b;
      logic        is_vertex;
      logic        poly_end;
      logic [6:0]  count;
   } clipped_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          csr_we = 1'b0;
   logic [1:0]    csr_index = CSR_PLANE_A;
   logic [31:0]   csr_wdata = '0;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [143:0]  req_tdata = '0;   // pos_x, pos_y, pos_z, col_r, col_g, col_b
   logic          req_tlast = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [151:0]  rsp_tdata;       // out_x, out_y, out_z, out_r, out_g, out_b, vertex_count
   logic          rsp_tuser;       // is_vertex
   logic          rsp_tlast;

   // Predictor state.
   logic signed [31:0] plane_coef [4];
   corner_type  first_corner, prev_corner;
   bit          at_start = 1'b1;
   int          emitted = 0;
   clipped_type clipped_q [$];

   int  errors = 0;
   int  items_sent = 0;
   int  results_seen = 0;
   int  markers_seen = 0;
   int  quiet_cycles = 0;
   bit  steady = 1'b0;

   clip_polygon_against_plane_unit #(.MAX_POLY_VERTICES(VertexCap)) i_dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------- predictor ----------------
   function automatic longint clamp_add(longint p, longint q);
      longint s;
      s = p + q;
      if (p > 0 && q > 0 && s < 0) s = 64'h7fff_ffff_ffff_ffff;
      else if (p < 0 && q < 0 && s >= 0) s = 64'h8000_0000_0000_0000;
      return s;
   endfunction

   function automatic longint plane_of(longint x, longint y, longint z);
      longint s, a, b, c, d;
      a = longint'(plane_coef[CSR_PLANE_A]);
      b = longint'(plane_coef[CSR_PLANE_B]);
      c = longint'(plane_coef[CSR_PLANE_C]);
      d = longint'(plane_coef[CSR_PLANE_D]);
      s = a * x;
      s = clamp_add(s, b * y);
      s = clamp_add(s, c * z);
      return clamp_add(s, d * 65536);
   endfunction

   // Crossing fraction in Q1.16 by restoring division on magnitudes.
   function automatic int unsigned crossing_t(longint f0, longint f1);
      bit [63:0]   num, den, rem, rem2;
      int unsigned q;
      bit          top;
      num = (f0 < 0) ? 64'd0 - 64'(f0) : 64'(f0);
      den = num + ((f1 < 0) ? 64'd0 - 64'(f1) : 64'(f1));
      rem = num;
      q = 0;
      if (den == 0) return 0;
      if (num >= den) return 65536;
      for (int i = 0; i < 16; i++) begin
         top = rem[63];
         rem2 = rem << 1;
         q = q << 1;
         if (top || rem2 >= den) begin
            rem2 = rem2 - den;
            q = q | 1;
         end
         rem = rem2;
      end
      return q;
   endfunction

   function automatic longint blend(longint v0, longint v1, int unsigned t);
      longint prod;
      prod = (v1 - v0) * longint'(t);
      return v0 + prod / 65536;
   endfunction

   function automatic void push_vertex(corner_type v, bit isv);
      clipped_type e;
      if (isv && emitted < CountSat) emitted++;
      e.x = v.p[0][31:0];
      e.y = v.p[1][31:0];
      e.z = v.p[2][31:0];
      e.r = v.c[0][15:0];
      e.g = v.c[1][15:0];
      e.b = v.c[2][15:0];
      e.is_vertex = isv;
      e.poly_end = 1'b0;
      e.count = emitted[6:0];
      clipped_q.push_back(e);
   endfunction

   function automatic int clip_edge(corner_type v0, corner_type v1);
      corner_type  m;
      int unsigned t;
      int          n;
      n = 0;
      if ((v0.f > 0) != (v1.f > 0)) begin
         t = crossing_t(v0.f, v1.f);
         for (int j = 0; j < 3; j++) begin
            m.p[j] = blend(v0.p[j], v1.p[j], t);
            m.c[j] = 32'(blend(longint'(v0.c[j]), longint'(v1.c[j]), t));
         end
         push_vertex(m, 1'b1);
         n++;
      end
      if (v1.f > 0) begin
         push_vertex(v1, 1'b1);
         n++;
      end
      return n;
   endfunction

   function automatic void predict_vertex(logic [143:0] data, bit last);
      corner_type cur;
      corner_type blank;
      int         n;
      n = 0;
      for (int j = 0; j < 3; j++) begin
         cur.p[j] = longint'($signed(data[32*j +: 32]));
         cur.c[j] = 32'(data[96 + 16*j +: 16]);
         blank.p[j] = 0;
         blank.c[j] = 0;
      end
      cur.f = plane_of(cur.p[0], cur.p[1], cur.p[2]);
      if (at_start) begin
         first_corner = cur;
         emitted = 0;
      end else begin
         n += clip_edge(prev_corner, cur);
      end
      if (last) begin
         n += clip_edge(cur, first_corner);
         if (n == 0) push_vertex(blank, 1'b0);
         clipped_q[clipped_q.size()-1].poly_end = 1'b1;
         at_start = 1'b1;
         emitted = 0;
      end else begin
         prev_corner = cur;
         at_start = 1'b0;
      end
   endfunction

   // ---------------- drivers ----------------
   function automatic bit take_gap();
      return !steady && ($urandom_range(0, 99) < 26);
   endfunction

   always @(negedge clock) begin
      rsp_tready <= !reset && !take_gap();
   end

   task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [15:0] r, logic [15:0] g, logic [15:0] b, bit last);
      while (take_gap()) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {b, g, r, z, y, x};
      req_tlast = last;
      do @(posedge clock); while (!req_tready);
      predict_vertex({b, g, r, z, y, x}, last);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_plane(logic [1:0] idx, logic [31:0] value);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      plane_coef[idx] = value;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_plane(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] d);
      write_plane(CSR_PLANE_A, a);
      write_plane(CSR_PLANE_B, b);
      write_plane(CSR_PLANE_C, c);
      write_plane(CSR_PLANE_D, d);
   endtask

   // Waits until every predicted beat has been seen, then lets the design settle before returning.
   task automatic drain();
      req_tvalid = 1'b0;
      while (clipped_q.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_coord(bit wide);
      if (wide || $urandom_range(0, 9) == 0) return $urandom;
      return $urandom_range(0, 524288) - 262144;
   endfunction

   task automatic send_random_polygon(int len, bit wide);
      for (int i = 0; i < len; i++) begin
         send_vertex(pick_coord(wide), pick_coord(wide), pick_coord(wide),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                     16'($urandom_range(0, 65535)), i == len - 1);
      end
   endtask

   // ---------------- result checker ----------------
   always @(posedge clock) begin
      clipped_type e;
      clipped_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         results_seen++;
         got.x = rsp_tdata[31:0];
         got.y = rsp_tdata[63:32];
         got.z = rsp_tdata[95:64];
         got.r = rsp_tdata[111:96];
         got.g = rsp_tdata[127:112];
         got.b = rsp_tdata[143:128];
         got.count = rsp_tdata[150:144];
         got.is_vertex = rsp_tuser;
         got.poly_end = rsp_tlast;
         if (!got.is_vertex) markers_seen++;
         if (clipped_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected beat: x=%h y=%h z=%h", got.x, got.y, got.z);
         end else begin
            e = clipped_q.pop_front();
            if (got !== e) begin
               errors++;
               if (errors <= 10) begin
                  $display("mismatch expected x=%h y=%h z=%h r=%h g=%h b=%h v=%b e=%b n=%0d",
                           e.x, e.y, e.z, e.r, e.g, e.b, e.is_vertex, e.poly_end, e.count);
                  $display("         actual   x=%h y=%h z=%h r=%h g=%h b=%h v=%b e=%b n=%0d",
                           got.x, got.y, got.z, got.r, got.g, got.b, got.is_vertex,
                           got.poly_end, got.count);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ---------------- tests ----------------
   // With an all-zero plane every vertex lies on it and counts as outside.
   task automatic test_zero_plane();
      send_vertex(32'h0001_0000, 32'h0, 32'h0, 16'hffff, 16'h0, 16'h1234, 1'b1);
      send_vertex(32'h7fff_ffff, 32'h8000_0000, 32'h0, 16'h0, 16'hffff, 16'h0, 1'b0);
      send_vertex(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff, 1'b1);
      drain();
   endtask

   // Plane x > 0: crossings in both directions, a vertex exactly on the plane,
   // single vertices on each side and extreme field values.
   task automatic test_x_half_space();
      set_plane(32'h0001_0000, 32'h0, 32'h0, 32'h0);
      send_vertex(32'h0001_0000, 32'h0, 32'h0, 16'hffff, 16'h0, 16'h0, 1'b0);
      send_vertex(32'hffff_0000, 32'h0001_0000, 32'h0, 16'h0, 16'hffff, 16'h0, 1'b0);
      send_vertex(32'hffff_0000, 32'hffff_0000, 32'h0003_0000, 16'h0, 16'h0, 16'hffff, 1'b1);
      send_vertex(32'h0000_0000, 32'h0005_0000, 32'h0, 16'h8000, 16'h8000, 16'h8000, 1'b1);
      send_vertex(32'h0000_0001, 32'h0, 32'h0, 16'h0001, 16'h0002, 16'h0003, 1'b1);
      send_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 16'hffff, 16'hffff, 16'hffff,
                  1'b0);
      send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0, 16'h0, 16'h0, 1'b1);
      send_vertex(32'hffff_0000, 32'h1, 32'h2, 16'h1, 16'h2, 16'h3, 1'b0);
      send_vertex(32'hfffe_0000, 32'h3, 32'h4, 16'h4, 16'h5, 16'h6, 1'b1);
      drain();
   endtask

   // The plane moves between two vertices of the same polygon.
   task automatic test_plane_change_mid_polygon();
      send_vertex(32'h0002_0000, 32'h0001_0000, 32'h0, 16'h1000, 16'h2000, 16'h3000, 1'b0);
      send_vertex(32'hfffd_0000, 32'h0002_0000, 32'h0, 16'h4000, 16'h5000, 16'h6000, 1'b0);
      drain();
      set_plane(32'h0, 32'h0001_0000, 32'h0, 32'hffff_8000);
      send_vertex(32'h0001_0000, 32'hfffc_0000, 32'h0007_0000, 16'hfff0, 16'h0, 16'h7777, 1'b1);
      drain();
   endtask

   // A polygon longer than the vertex limit drives the count into saturation.
   task automatic test_count_saturation();
      set_plane(32'h0, 32'h0, 32'h0, 32'h0001_0000);
      send_random_polygon(70, 1'b1);
      drain();
   endtask

   task automatic test_random_planes();
      for (int phase = 0; phase < 5; phase++) begin
         int n;
         n = 0;
         steady = (phase == 2);
         case (phase)
            3: set_plane(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
            4: set_plane(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
            default: set_plane($urandom_range(0, 131072) - 65536,
                               $urandom_range(0, 131072) - 65536,
                               $urandom_range(0, 131072) - 65536,
                               $urandom_range(0, 262144) - 131072);
         endcase
         while (n < 56) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 14) : $urandom_range(1, 8);
            send_random_polygon(len, phase >= 3);
            n += len;
         end
         drain();
      end
      steady = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < 4; i++) plane_coef[i] = '0;
      repeat (4) @(negedge clock);
      reset = 1'b0;
      test_zero_plane();
      test_x_half_space();
      test_plane_change_mid_polygon();
      test_count_saturation();
      test_random_planes();
      $display("Sent %0d vertices in zero, extreme and random planes; checked %0d beats,",
               items_sent, results_seen);
      $display("%0d of them end markers, %0d left unmatched.", markers_seen, clipped_q.size());
      if (errors == 0 && clipped_q.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/cpap_pkg.sv
hw/rtl/cpap_front.sv
hw/rtl/cpap_queue.sv
hw/rtl/cpap_back.sv
hw/rtl/clip_polygon_against_plane_unit.sv
tb/sv/tb.sv
